>>> sv/oact_pkg.sv
// Shared types and constants for the open addressing connection table.
// Holds the controller state type, the command and status bundles and the field codes.
// Depends on nothing.
package oact_pkg;

    // Defaults for the top level parameters.
    localparam int unsigned DEF_SLOT_COUNT  = 4096;
    localparam int unsigned DEF_HANDLE_BITS = 48;

    // Multiplicative hash constant; only its low bits reach the home slot.
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Request types.
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_OPEN   = 2'd1;
    localparam logic [1:0] REQ_CLOSE  = 2'd2;

    // Slot marks.
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    // Response status codes.
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_DELIVER
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take the request beat and set up the probe
        logic clear;     // write one empty mark of the clearing pass
        logic probe_rd;  // read the slot under the probe pointer
        logic check;     // evaluate the slot just read
        logic deliver;   // move the result into the response register
    } oact_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // the clearing pass writes its final slot
        logic probe_stop;  // the probe run ends on the slot just read
        logic out_free;    // the response register can take a result
    } oact_stat_t;

endpackage

>>> sv/oact_ctrl.sv
// Controller for the connection table: sequences clearing, probing and delivery.
// Depends on oact_pkg.
module oact_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  oact_pkg::oact_stat_t stat,
    output oact_pkg::oact_cmd_t  cmd
);
    import oact_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = stat.probe_stop ? S_DELIVER : S_PROBE;
            end
            S_DELIVER:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            S_PROBE:
            begin
                cmd.probe_rd = 1'b1;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            S_DELIVER:
            begin
                cmd.deliver = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/oact_dpath.sv
// Datapath for the connection table: hash, slot memories, probe registers and result.
// Depends on oact_pkg; driven by commands from oact_ctrl.
module oact_dpath #(
    parameter int unsigned SLOT_COUNT  = oact_pkg::DEF_SLOT_COUNT,
    parameter int unsigned HANDLE_BITS = oact_pkg::DEF_HANDLE_BITS,
    localparam int unsigned SLOT_BITS  = $clog2(SLOT_COUNT)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  oact_pkg::oact_cmd_t    cmd,
    output oact_pkg::oact_stat_t   stat,
    input  logic [1:0]             req_type,
    input  logic [HANDLE_BITS-1:0] handle,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [2:0]             status,
    output logic [SLOT_BITS-1:0]   slot_index
);
    import oact_pkg::*;

    localparam logic [SLOT_BITS-1:0] MULT_LO   = HASH_MULT[SLOT_BITS-1:0];
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOT_COUNT - 1);

    // Slot stores.
    logic [1:0]             mark_mem [SLOT_COUNT];
    logic [HANDLE_BITS-1:0] key_mem  [SLOT_COUNT];

    // Request and probe state.
    logic [1:0]             op_reg;
    logic [HANDLE_BITS-1:0] key_reg;
    logic [SLOT_BITS-1:0]   probe_addr_reg;
    logic [SLOT_BITS-1:0]   probe_addr_next;
    logic [SLOT_BITS-1:0]   probe_cnt_reg;
    logic [SLOT_BITS-1:0]   probe_cnt_next;
    logic                   have_free_reg;
    logic                   have_free_next;
    logic [SLOT_BITS-1:0]   free_at_reg;
    logic [SLOT_BITS-1:0]   free_at_next;
    logic [SLOT_BITS-1:0]   clr_cnt_reg;
    logic [1:0]             rd_mark_reg;
    logic [HANDLE_BITS-1:0] rd_key_reg;

    // Result and response registers.
    logic [2:0]             res_status_reg;
    logic [2:0]             res_status_next;
    logic [SLOT_BITS-1:0]   res_idx_reg;
    logic [SLOT_BITS-1:0]   res_idx_next;
    logic                   out_valid_reg;
    logic [2:0]             out_status_reg;
    logic [SLOT_BITS-1:0]   out_idx_reg;

    // Combinational probe evaluation.
    logic [SLOT_BITS-1:0]   home;
    logic                   hit_now;
    logic                   empty_now;
    logic                   tomb_now;
    logic                   stop_now;
    logic                   free_final;
    logic [SLOT_BITS-1:0]   free_at_final;
    logic                   mark_we;
    logic [SLOT_BITS-1:0]   mark_waddr;
    logic [1:0]             mark_wdata;
    logic                   key_we;

    // Home slot: the low bits of the product need only the low bits of each factor.
    assign home = handle[SLOT_BITS-1:0] * MULT_LO;

    // Classify the slot just read.
    assign hit_now   = (rd_mark_reg == MARK_LIVE) && (rd_key_reg == key_reg);
    assign empty_now = (rd_mark_reg == MARK_EMPTY);
    assign tomb_now  = (rd_mark_reg == MARK_TOMB);
    assign stop_now  = hit_now || empty_now || (probe_cnt_reg == LAST_SLOT);

    assign free_final    = have_free_reg || empty_now || tomb_now;
    assign free_at_final = have_free_reg ? free_at_reg : probe_addr_reg;

    // Decide the result and the slot update when the probe run ends.
    always_comb
    begin
        res_status_next = ST_NOT_FOUND;
        res_idx_next    = '0;
        mark_we         = 1'b0;
        mark_waddr      = clr_cnt_reg;
        mark_wdata      = MARK_EMPTY;
        key_we          = 1'b0;
        if (cmd.clear)
        begin
            mark_we = 1'b1;
        end
        else if (cmd.check && stop_now)
        begin
            if (op_reg == REQ_CLOSE)
            begin
                if (hit_now)
                begin
                    mark_we         = 1'b1;
                    mark_waddr      = probe_addr_reg;
                    mark_wdata      = MARK_TOMB;
                    res_status_next = ST_REMOVED;
                    res_idx_next    = probe_addr_reg;
                end
            end
            else if (hit_now)
            begin
                res_status_next = ST_FOUND;
                res_idx_next    = probe_addr_reg;
            end
            else if (op_reg == REQ_OPEN)
            begin
                if (free_final)
                begin
                    mark_we         = 1'b1;
                    key_we          = 1'b1;
                    mark_waddr      = free_at_final;
                    mark_wdata      = MARK_LIVE;
                    res_status_next = ST_INSERTED;
                    res_idx_next    = free_at_final;
                end
                else
                begin
                    res_status_next = ST_FULL;
                end
            end
        end
    end

    // Next values of the probe registers.
    always_comb
    begin
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        have_free_next  = have_free_reg;
        free_at_next    = free_at_reg;
        if (cmd.load)
        begin
            probe_addr_next = home;
            probe_cnt_next  = '0;
            have_free_next  = 1'b0;
        end
        else if (cmd.check && !stop_now)
        begin
            // Linear probe; the pointer wraps past the last slot by its width.
            probe_addr_next = probe_addr_reg + 1'b1;
            probe_cnt_next  = probe_cnt_reg + 1'b1;
            have_free_next  = free_final;
            free_at_next    = free_at_final;
        end
    end

    // Mark store with its registered read port.
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (cmd.probe_rd)
        begin
            rd_mark_reg <= mark_mem[probe_addr_reg];
        end
    end

    // Key store; written only on insertion, so no clearing pass.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[mark_waddr] <= key_reg;
        end
        if (cmd.probe_rd)
        begin
            rd_key_reg <= key_mem[probe_addr_reg];
        end
    end

    // Request and probe payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req_type;
            key_reg <= handle;
        end
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg  <= probe_cnt_next;
        have_free_reg  <= have_free_next;
        free_at_reg    <= free_at_next;
        if (cmd.check && stop_now)
        begin
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
        end
    end

    // Clearing pass counter; walks every slot once after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Response register; a waiting beat does not hold up the next request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.deliver && stat.out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver && stat.out_free)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
        end
    end

    // Status back to the controller.
    assign stat.clear_last = (clr_cnt_reg == LAST_SLOT);
    assign stat.probe_stop = stop_now;
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot_index = out_idx_reg;

endmodule

>>> sv/open_addressing_connection_table_top.sv
// Top level of the open addressing connection table.
// Instantiates oact_ctrl and oact_dpath; depends on oact_pkg.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_type, handle
//   rsp      out        rsp_valid / rsp_ready  status, slot_index
//
// A request is loaded, probed slot by slot and delivered; it probes 1 to SLOT_COUNT
// slots, and each probe is one read of the slot memories and one check.
// After reset a clearing pass writes every mark empty, with req_ready low
// throughout. A response beat waits in its own register, so the next request
// is taken while rsp_ready is low; only its delivery then stalls.
// SLOT_COUNT must be a power of two.
module open_addressing_connection_table_top #(
    parameter int unsigned SLOT_COUNT  = oact_pkg::DEF_SLOT_COUNT,
    parameter int unsigned HANDLE_BITS = oact_pkg::DEF_HANDLE_BITS,
    localparam int unsigned SLOT_BITS  = $clog2(SLOT_COUNT)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic [1:0]             req_type,
    input  logic [HANDLE_BITS-1:0] handle,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [2:0]             status,
    output logic [SLOT_BITS-1:0]   slot_index
);
    import oact_pkg::*;

    oact_cmd_t  cmd;
    oact_stat_t stat;

    // Sequencer.
    oact_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Slot stores and probe logic.
    oact_dpath #(
        .SLOT_COUNT  (SLOT_COUNT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .handle     (handle),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .slot_index (slot_index)
    );

endmodule
